/* rtl/lds_pkg.sv */
// Shared types for the linear Diophantine solver: transfer payloads and sequencer states.
package lds_pkg;

  typedef struct packed {
    logic signed [31:0] a;
    logic signed [31:0] b;
    logic signed [31:0] c;
  } req_t;

  typedef struct packed {
    logic               solvable;
    logic signed [63:0] x_coef;
    logic signed [63:0] y_coef;
    logic        [31:0] gcd_value;
  } res_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TEST,
    ST_EUC_WAIT,
    ST_FIN_WAIT,
    ST_OUT
  } lds_state_e;

endpackage

/* rtl/lds_divider.sv */
// Restoring bit-serial divider with two shift-add accumulators that form quotient * multiplier.
module lds_divider #(
  parameter int WIDTH = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic        [WIDTH-1:0]       dividend_i,
  input  logic        [WIDTH-1:0]       divisor_i,
  input  logic signed [WIDTH:0]         mult_a_i,
  input  logic signed [WIDTH:0]         mult_b_i,
  output logic                          done_o,
  output logic        [WIDTH-1:0]       rem_o,
  output logic signed [2*WIDTH-1:0]     prod_a_o,
  output logic signed [2*WIDTH-1:0]     prod_b_o
);

  localparam int AccW = 2 * WIDTH;
  localparam int CntW = $clog2(WIDTH + 1);

  logic                   busy_q, busy_d;
  logic                   done_q, done_d;
  logic [CntW-1:0]        cnt_q, cnt_d;
  logic [WIDTH-1:0]       num_q, num_d;
  logic [WIDTH-1:0]       den_q, den_d;
  logic [WIDTH-1:0]       rem_q, rem_d;
  logic signed [AccW-1:0] ma_q, ma_d;
  logic signed [AccW-1:0] mb_q, mb_d;
  logic signed [AccW-1:0] acc_a_q, acc_a_d;
  logic signed [AccW-1:0] acc_b_q, acc_b_d;
  logic [WIDTH:0]         rem_sh;
  logic [WIDTH:0]         diff;
  logic                   qbit;

  always_comb begin
    rem_sh  = {rem_q, num_q[WIDTH-1]};
    diff    = rem_sh - {1'b0, den_q};
    qbit    = ~diff[WIDTH];
    busy_d  = busy_q;
    done_d  = 1'b0;
    cnt_d   = cnt_q;
    num_d   = num_q;
    den_d   = den_q;
    rem_d   = rem_q;
    ma_d    = ma_q;
    mb_d    = mb_q;
    acc_a_d = acc_a_q;
    acc_b_d = acc_b_q;
    if (start_i) begin
      busy_d  = 1'b1;
      cnt_d   = CntW'(WIDTH);
      num_d   = dividend_i;
      den_d   = divisor_i;
      rem_d   = '0;
      ma_d    = AccW'(mult_a_i);
      mb_d    = AccW'(mult_b_i);
      acc_a_d = '0;
      acc_b_d = '0;
    end else if (busy_q) begin
      // one quotient bit per cycle, MSB first; fold it into both products
      rem_d   = qbit ? diff[WIDTH-1:0] : rem_sh[WIDTH-1:0];
      num_d   = {num_q[WIDTH-2:0], 1'b0};
      acc_a_d = (acc_a_q <<< 1) + (qbit ? ma_q : '0);
      acc_b_d = (acc_b_q <<< 1) + (qbit ? mb_q : '0);
      cnt_d   = cnt_q - CntW'(1);
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q   <= num_d;
    den_q   <= den_d;
    rem_q   <= rem_d;
    ma_q    <= ma_d;
    mb_q    <= mb_d;
    acc_a_q <= acc_a_d;
    acc_b_q <= acc_b_d;
  end

  assign done_o   = done_q;
  assign rem_o    = rem_q;
  assign prod_a_o = acc_a_q;
  assign prod_b_o = acc_b_q;

endmodule

/* rtl/linear_diophantine_solver.sv */
// Top level: finds one integer solution of a*x + b*y = c with the extended Euclidean algorithm.
// Usage:
//   Request channel: req_i (a, b, c) is taken at a rising edge where start_i is high and
//   busy_o is low. Only the low DATA_WIDTH bits of each field count, as two's complement.
//   busy_o stays high from that edge until the result has been shown; one item at a time.
//   Result channel: valid_o is high for exactly one cycle with res_o (solvable, x_coef,
//   y_coef, gcd_value); the receiver takes it at the edge ending that cycle and cannot stall.
// Datapath:
//   Every Euclid step and the final scaling step run through one restoring divider that
//   makes one quotient bit per cycle and accumulates quotient * Bezout coefficient alongside.
//   Each Euclid step issues the division from the test state, lets the divider form the
//   quotient bits, then takes the remainder and the new Bezout pair back in the wait state.
//   For DATA_WIDTH = 32 an item has at most 45 Euclid steps (|a| < |b| adds one swap step to
//   the Fibonacci worst case). With a = b = 0 no division runs at all.
// Reset:
//   rst_ni clears the sequencer to idle; an item in flight is dropped and no result follows.
//   No clearing pass is needed; the block is ready in the first cycle after reset.
module linear_diophantine_solver #(
  parameter int DATA_WIDTH = 32
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  lds_pkg::req_t req_i,
  output logic          busy_o,
  output logic          valid_o,
  output lds_pkg::res_t res_o
);

  localparam int W    = DATA_WIDTH;
  localparam int SW   = DATA_WIDTH + 1;
  localparam int AccW = 2 * DATA_WIDTH;

  lds_pkg::lds_state_e state_q, state_d;

  logic [W-1:0]         r0_q, r0_d, r1_q, r1_d, mc_q, mc_d;
  logic signed [SW-1:0] s0_q, s0_d, s1_q, s1_d, t0_q, t0_d, t1_q, t1_d;
  logic                 na_q, na_d, nb_q, nb_d, nc_q, nc_d;
  lds_pkg::res_t        res_q, res_d;

  logic                   div_start;
  logic [W-1:0]           div_dividend, div_divisor;
  logic signed [SW-1:0]   div_ma, div_mb;
  logic                   div_done;
  logic [W-1:0]           div_rem;
  logic signed [AccW-1:0] div_pa, div_pb;

  logic signed [AccW-1:0] s_next, t_next, x_val, y_val;
  logic                   fin_ok;

  function automatic logic [W-1:0] mag_of(input logic [31:0] raw);
    logic [W-1:0] v;
    v = raw[W-1:0];
    return v[W-1] ? (~v + W'(1)) : v;
  endfunction

  lds_divider #(
    .WIDTH(W)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(div_dividend),
    .divisor_i (div_divisor),
    .mult_a_i  (div_ma),
    .mult_b_i  (div_mb),
    .done_o    (div_done),
    .rem_o     (div_rem),
    .prod_a_o  (div_pa),
    .prod_b_o  (div_pb)
  );

  always_comb begin
    state_d      = state_q;
    r0_d         = r0_q;
    r1_d         = r1_q;
    mc_d         = mc_q;
    s0_d         = s0_q;
    s1_d         = s1_q;
    t0_d         = t0_q;
    t1_d         = t1_q;
    na_d         = na_q;
    nb_d         = nb_q;
    nc_d         = nc_q;
    res_d        = res_q;
    div_start    = 1'b0;
    div_dividend = r0_q;
    div_divisor  = r1_q;
    div_ma       = s1_q;
    div_mb       = t1_q;
    s_next       = AccW'(s0_q) - div_pa;
    t_next       = AccW'(t0_q) - div_pb;
    fin_ok       = (div_rem == '0);
    x_val        = (na_q ^ nc_q) ? -div_pa : div_pa;
    y_val        = (nb_q ^ nc_q) ? -div_pb : div_pb;

    case (state_q)
      lds_pkg::ST_IDLE: begin
        if (start_i) begin
          r0_d    = mag_of(req_i.a);
          r1_d    = mag_of(req_i.b);
          mc_d    = mag_of(req_i.c);
          na_d    = req_i.a[W-1];
          nb_d    = req_i.b[W-1];
          nc_d    = req_i.c[W-1];
          s0_d    = SW'(1);
          s1_d    = '0;
          t0_d    = '0;
          t1_d    = SW'(1);
          state_d = lds_pkg::ST_TEST;
        end
      end
      lds_pkg::ST_TEST: begin
        if (r1_q != '0) begin
          div_start = 1'b1;
          state_d   = lds_pkg::ST_EUC_WAIT;
        end else if (r0_q == '0) begin
          // both coefficients zero: only c = 0 has a solution
          res_d.solvable  = (mc_q == '0);
          res_d.x_coef    = '0;
          res_d.y_coef    = '0;
          res_d.gcd_value = '0;
          state_d         = lds_pkg::ST_OUT;
        end else begin
          // scale Bezout pair by |c| / g and check the remainder
          div_start    = 1'b1;
          div_dividend = mc_q;
          div_divisor  = r0_q;
          div_ma       = s0_q;
          div_mb       = t0_q;
          state_d      = lds_pkg::ST_FIN_WAIT;
        end
      end
      lds_pkg::ST_EUC_WAIT: begin
        if (div_done) begin
          r0_d    = r1_q;
          r1_d    = div_rem;
          s0_d    = s1_q;
          s1_d    = s_next[SW-1:0];
          t0_d    = t1_q;
          t1_d    = t_next[SW-1:0];
          state_d = lds_pkg::ST_TEST;
        end
      end
      lds_pkg::ST_FIN_WAIT: begin
        if (div_done) begin
          res_d.solvable  = fin_ok;
          res_d.x_coef    = fin_ok ? 64'(x_val) : '0;
          res_d.y_coef    = fin_ok ? 64'(y_val) : '0;
          res_d.gcd_value = 32'(r0_q);
          state_d         = lds_pkg::ST_OUT;
        end
      end
      lds_pkg::ST_OUT: begin
        state_d = lds_pkg::ST_IDLE;
      end
      default: begin
        state_d = lds_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lds_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    r0_q  <= r0_d;
    r1_q  <= r1_d;
    mc_q  <= mc_d;
    s0_q  <= s0_d;
    s1_q  <= s1_d;
    t0_q  <= t0_d;
    t1_q  <= t1_d;
    na_q  <= na_d;
    nb_q  <= nb_d;
    nc_q  <= nc_d;
    res_q <= res_d;
  end

  assign busy_o  = (state_q != lds_pkg::ST_IDLE);
  assign valid_o = (state_q == lds_pkg::ST_OUT);
  assign res_o   = res_q;

endmodule

/* verif/linear_diophantine_solver_test.sv */
// Self-checking testbench for linear_diophantine_solver: directed corners plus random equations.
`timescale 1ns / 1ps

module linear_diophantine_solver_test;

  logic          clk_i;
  logic          rst_ni;
  logic          start_i;
  lds_pkg::req_t req_i;
  logic          busy_o;
  logic          valid_o;
  lds_pkg::res_t res_o;

  lds_pkg::res_t solutions_pending[$];
  int            mismatch_count;
  int            idle_max;

  linear_diophantine_solver u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i),
    .req_i  (req_i),
    .busy_o (busy_o),
    .valid_o(valid_o),
    .res_o  (res_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Extended Euclid on the magnitudes, then scale by c/g and fix signs.
  function automatic lds_pkg::res_t solve_equation(lds_pkg::req_t eq);
    longint unsigned rem_prev, rem_cur, rem_next, quot;
    longint s_prev, s_cur, s_next, t_prev, t_cur, t_next;
    longint av, bv, rhs, gcd, scale;
    lds_pkg::res_t sol;
    av = longint'($signed(eq.a));
    bv = longint'($signed(eq.b));
    rhs = longint'($signed(eq.c));
    rem_prev = (av < 0) ? -av : av;
    rem_cur = (bv < 0) ? -bv : bv;
    s_prev = 1;
    s_cur = 0;
    t_prev = 0;
    t_cur = 1;
    for (int step = 0; step < 96 && rem_cur != 0; step++) begin
      quot = rem_prev / rem_cur;
      rem_next = rem_prev - quot * rem_cur;
      s_next = s_prev - longint'(quot) * s_cur;
      t_next = t_prev - longint'(quot) * t_cur;
      rem_prev = rem_cur;
      rem_cur = rem_next;
      s_prev = s_cur;
      s_cur = s_next;
      t_prev = t_cur;
      t_cur = t_next;
    end
    gcd = longint'(rem_prev);
    sol = '0;
    sol.gcd_value = gcd[31:0];
    if (gcd == 0) begin
      sol.solvable = (rhs == 0);
    end else if (rhs % gcd != 0) begin
      sol.solvable = 1'b0;
    end else begin
      scale = rhs / gcd;
      sol.solvable = 1'b1;
      sol.x_coef = (av < 0) ? -(s_prev * scale) : s_prev * scale;
      sol.y_coef = (bv < 0) ? -(t_prev * scale) : t_prev * scale;
    end
    return sol;
  endfunction

  function automatic void note_mismatch(string what, longint want, longint got);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("mismatch %s: expected %0d, got %0d at %0t", what, want, got, $realtime);
  endfunction

  // Called at a rising edge; returns at the edge where the transfer happens.
  task automatic issue_equation(logic signed [31:0] a, logic signed [31:0] b,
                                logic signed [31:0] c);
    int gap;
    lds_pkg::req_t eq;
    gap = (idle_max == 0) ? 0 : $urandom_range(0, idle_max);
    eq.a = a;
    eq.b = b;
    eq.c = c;
    if (gap > 0) begin
      // hold off until the busy period has ended, then wait out the random gap
      start_i <= 1'b0;
      @(posedge clk_i);
      while (busy_o) @(posedge clk_i);
      repeat (gap - 1) @(posedge clk_i);
    end
    start_i <= 1'b1;
    req_i <= eq;
    do @(posedge clk_i); while (busy_o);
    // newest at the front, oldest taken from the back
    solutions_pending.push_front(solve_equation(eq));
  endtask

  always @(posedge clk_i) begin : check_results
    lds_pkg::res_t want;
    if (rst_ni && valid_o) begin
      if (solutions_pending.size() == 0) begin
        note_mismatch("result with nothing pending, gcd_value", -1, res_o.gcd_value);
      end else begin
        want = solutions_pending.pop_back();
        if (res_o.solvable !== want.solvable)
          note_mismatch("solvable", want.solvable, res_o.solvable);
        if (res_o.x_coef !== want.x_coef)
          note_mismatch("x_coef", want.x_coef, res_o.x_coef);
        if (res_o.y_coef !== want.y_coef)
          note_mismatch("y_coef", want.y_coef, res_o.y_coef);
        if (res_o.gcd_value !== want.gcd_value)
          note_mismatch("gcd_value", want.gcd_value, res_o.gcd_value);
      end
    end
  end

  function automatic logic signed [31:0] corner_value();
    case ($urandom_range(0, 8))
      0: return 32'sd0;
      1: return 32'sd1;
      2: return -32'sd1;
      3: return 32'h8000_0000;
      4: return 32'h7fff_ffff;
      5: return 32'h8000_0001;
      6: return 32'h7fff_fffe;
      7: return 32'($signed($urandom_range(0, 64)) - 32);
      default: return 32'($urandom());
    endcase
  endfunction

  // Random value in [-span, span - 1].
  function automatic longint spread(longint span);
    return longint'($urandom_range(0, 32'(2 * span - 1))) - span;
  endfunction

  task automatic test_corners();
    idle_max = 19;
    issue_equation(0, 0, 0);
    issue_equation(0, 0, 5);
    issue_equation(0, 0, 32'h8000_0000);
    issue_equation(7, 0, 21);
    issue_equation(0, -7, 21);
    issue_equation(0, 9, 4);
    issue_equation(6, 10, 3);
    issue_equation(6, -10, 8);
    issue_equation(-6, 10, -8);
    issue_equation(-6, -10, 32'h7fff_fffe);
    issue_equation(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    issue_equation(32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff);
    issue_equation(32'h8000_0000, 0, 32'h8000_0000);
    issue_equation(32'h8000_0000, 32'h7fff_ffff, 1);
    issue_equation(32'h8000_0000, 1, 32'h8000_0000);
    issue_equation(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
    issue_equation(32'h7fff_ffff, 32'h7fff_fffe, 32'h8000_0000);
    issue_equation(-1, -1, -1);
    issue_equation(1, 1, 0);
    // consecutive Fibonacci numbers give the longest Euclid chain
    issue_equation(32'sd1836311903, 32'sd1134903170, 1);
    issue_equation(-32'sd1836311903, 32'sd1134903170, 32'h8000_0000);
    issue_equation(32'sd1134903170, -32'sd1836311903, 32'h7fff_ffff);
    issue_equation(32'hffff_ffff, 32'h5555_5555, 32'haaaa_aaaa);
  endtask

  task automatic test_random_operands(int count);
    idle_max = 19;
    repeat (count) issue_equation(32'($urandom()), 32'($urandom()), 32'($urandom()));
  endtask

  // Shared factor g keeps most equations solvable; a few get a broken c or a zero operand.
  task automatic test_common_factor(int count);
    longint g, span, a, b, c;
    for (int n = 0; n < count; n++) begin
      if (n % 25 == 0) idle_max = (idle_max == 0) ? 19 : 0;
      g = longint'($urandom_range(1, 1 << $urandom_range(0, 20)));
      span = (longint'(1) << 31) / g;
      a = g * spread(span);
      b = g * spread(span);
      c = g * spread(span);
      case ($urandom_range(0, 9))
        0: a = 0;
        1: b = 0;
        2, 3: if (g > 1) c = c + ((c < 0) ? 1 : -1) * longint'($urandom_range(1, 32'(g - 1)));
        default: ;
      endcase
      issue_equation(32'(a), 32'(b), 32'(c));
    end
  endtask

  task automatic test_mixed_corners(int count);
    idle_max = 19;
    repeat (count) issue_equation(corner_value(), corner_value(), corner_value());
  endtask

  initial begin
    rst_ni = 1'b0;
    start_i = 1'b0;
    req_i = '0;
    mismatch_count = 0;
    idle_max = 19;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_corners();
    test_random_operands(100);
    test_common_factor(150);
    test_mixed_corners(100);
    start_i <= 1'b0;
    while (solutions_pending.size() != 0) @(posedge clk_i);
    // watch for stray results for about one worst-case item
    repeat (1700) @(posedge clk_i);
    if (mismatch_count == 0 && solutions_pending.size() == 0) begin
      $display("linear_diophantine_solver_test: clean");
    end else begin
      $display("linear_diophantine_solver_test: errors");
    end
    $finish;
  end

  initial begin
    #6_000_000;
    $display("linear_diophantine_solver_test: errors");
    $finish;
  end

endmodule

/* files.f */
rtl/lds_pkg.sv
rtl/lds_divider.sv
rtl/linear_diophantine_solver.sv
verif/linear_diophantine_solver_test.sv
